// ===== hw/rtl/tet_ray_exit_face_defines.svh =====
// assertion macros shared by the checker
`ifndef TET_RAY_EXIT_FACE_DEFINES_SVH
`define TET_RAY_EXIT_FACE_DEFINES_SVH

// implication checked outside reset
`define TEF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tef check failed");

// next-cycle implication checked at every edge
`define TEF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("tef check failed");

`endif

// ===== hw/rtl/tef_pkg.sv =====
// ----------------------------------------------------------------------------
// tef_pkg
// shared types and constants of the ray exit face block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tef_pkg;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 32;
    localparam int FACE_N = 4;

    typedef logic [1:0] face_t;

    typedef struct packed {
        logic  found;
        face_t face;
        logic  ovf;
    } tef_side_t;
endpackage

// ===== hw/rtl/tef_mul.sv =====
// ----------------------------------------------------------------------------
// tef_mul
// two-stage signed multiplier built from four half-width partial products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tef_mul #(
    parameter int W = 36
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);
    localparam int L = W / 2;
    localparam int H = W - L;

    logic signed [L:0]       al, bl;
    logic signed [H-1:0]     ah, bh;
    logic signed [2*L+1:0]   pp0_reg;
    logic signed [H+L:0]     pp1_reg, pp2_reg;
    logic signed [2*H-1:0]   pp3_reg;
    logic signed [2*W-1:0]   e0, e1, e2, e3, p_next, p_reg;

    assign al = $signed({1'b0, a[L-1:0]});
    assign bl = $signed({1'b0, b[L-1:0]});
    assign ah = a[W-1:L];
    assign bh = b[W-1:L];

    always_ff @(posedge aclk) begin
        if (en) begin
            pp0_reg <= al * bl;
            pp1_reg <= ah * bl;
            pp2_reg <= al * bh;
            pp3_reg <= ah * bh;
            p_reg   <= p_next;
        end
    end

    always_comb begin
        e0 = pp0_reg;
        e1 = pp1_reg;
        e2 = pp2_reg;
        e3 = pp3_reg;
        p_next = (e3 <<< (2 * L)) + ((e1 + e2) <<< L) + e0;
    end

    assign p = p_reg;
endmodule

// ===== hw/rtl/tef_div.sv =====
// ----------------------------------------------------------------------------
// tef_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tef_div #(
    parameter int QW = 35,
    parameter int DW = 67
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  tef_pkg::tef_side_t    in_side,
    input  logic [DW-1:0]         in_rem,
    input  logic [QW-1:0]         in_den,
    output logic                  out_valid,
    output tef_pkg::tef_side_t    out_side,
    output logic [tef_pkg::OUT_W-1:0] out_quo
);
    import tef_pkg::*;

    logic              st_valid [OUT_W+1];
    tef_side_t         st_side  [OUT_W+1];
    logic [DW-1:0]     st_rem   [OUT_W+1];
    logic [QW-1:0]     st_den   [OUT_W+1];
    logic [OUT_W-1:0]  st_quo   [OUT_W+1];

    assign st_valid[0] = in_valid;
    assign st_side[0]  = in_side;
    assign st_rem[0]   = in_rem;
    assign st_den[0]   = in_den;
    assign st_quo[0]   = '0;

    for (genvar j = 0; j < OUT_W; j++) begin : g_stage
        localparam int B = OUT_W - 1 - j;
        logic [DW-1:0] trial;
        logic          ge;
        logic          valid_reg;
        tef_side_t     side_reg;
        logic [DW-1:0] rem_reg;
        logic [QW-1:0] den_reg;
        logic [OUT_W-1:0] quo_reg;

        assign trial = DW'(st_den[j]) << B;
        assign ge    = st_rem[j] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg <= 1'b0;
            end else if (en) begin
                valid_reg <= st_valid[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg <= st_side[j];
                den_reg  <= st_den[j];
                rem_reg  <= ge ? st_rem[j] - trial : st_rem[j];
                quo_reg  <= st_quo[j] | (ge ? (OUT_W'(1) << B) : '0);
            end
        end

        assign st_valid[j+1] = valid_reg;
        assign st_side[j+1]  = side_reg;
        assign st_rem[j+1]   = rem_reg;
        assign st_den[j+1]   = den_reg;
        assign st_quo[j+1]   = quo_reg;
    end

    assign out_valid = st_valid[OUT_W];
    assign out_side  = st_side[OUT_W];
    assign out_quo   = st_quo[OUT_W];
endmodule

// ===== hw/rtl/tet_ray_exit_face.sv =====
// ----------------------------------------------------------------------------
// tet_ray_exit_face
// exit face and ray parameter of a ray inside a tetrahedron
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle and each passes through one input
// register, a two-stage multiplier bank, the face tests, the face selection,
// the overflow check, 32 divider stages (one quotient bit each) and the
// output register. A stall on the result side holds the whole pipeline.
`timescale 1ns / 1ps
module tet_ray_exit_face #(
    parameter int COORD_FRAC_BITS = 28,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_a, point_b, point_c, dir_a, dir_b, dir_c
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // exit_face, exit_param, zero fill
    output logic [39:0]  m_tdata,
    // hit_found
    output logic         m_tuser
);
    import tef_pkg::*;

    localparam int QW = (COORD_FRAC_BITS + 3 > 35) ? COORD_FRAC_BITS + 3 : 35;
    localparam int MW = QW + 1;
    localparam int DW = QW + OUT_W;
    localparam logic signed [QW-1:0] ONE = QW'(1) << COORD_FRAC_BITS;

    logic en;
    logic signed [QW-1:0] qin [FACE_N];
    logic signed [QW-1:0] din [FACE_N];

    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [QW-1:0] q1_reg [FACE_N], d1_reg [FACE_N];
    logic signed [QW-1:0] q2_reg [FACE_N], d2_reg [FACE_N];
    logic signed [QW-1:0] q3_reg [FACE_N], d3_reg [FACE_N];
    logic [QW-1:0]        mq1 [FACE_N], md1 [FACE_N];
    logic [QW-1:0]        mq4_reg [FACE_N], md4_reg [FACE_N];

    logic signed [2*QW-1:0] prod [FACE_N][FACE_N];
    logic signed [2*MW-1:0] mprod [FACE_N][FACE_N];

    logic [FACE_N-1:0]       ok_next, ok4_reg;
    logic [FACE_N-1:0]       gt_next [FACE_N];
    logic [FACE_N-1:0]       gt4_reg [FACE_N];

    logic          fnd_next, fnd5_reg;
    face_t         best_next, best5_reg;
    logic [QW-1:0] num5_reg, den5_reg;

    tef_side_t     side6_reg;
    logic [DW-1:0] rem6_reg;
    logic [QW-1:0] den6_reg;

    logic               dv_valid;
    tef_side_t          dv_side;
    logic [OUT_W-1:0]   dv_quo;

    logic               m_tvalid_reg;
    logic               hit_reg;
    face_t              face_reg;
    logic [OUT_W-1:0]   param_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qin[k] = QW'($signed(s_tdata[IN_W*k +: IN_W]));
            din[k] = QW'($signed(s_tdata[IN_W*(k+3) +: IN_W]));
        end
        qin[3] = ONE - qin[0] - qin[1] - qin[2];
        din[3] = -(din[0] + din[1] + din[2]);
        for (int k = 0; k < FACE_N; k++) begin
            mq1[k] = q1_reg[k][QW-1] ? QW'(-q1_reg[k]) : QW'(q1_reg[k]);
            md1[k] = d1_reg[k][QW-1] ? QW'(-d1_reg[k]) : QW'(d1_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    for (genvar i = 0; i < FACE_N; i++) begin : g_row
        for (genvar j = 0; j < FACE_N; j++) begin : g_col
            if (i != j) begin : g_mul
                // q_i * d_j
                tef_mul #(.W(QW)) u_prod (
                    .aclk (aclk),
                    .en   (en),
                    .a    (q1_reg[i]),
                    .b    (d1_reg[j]),
                    .p    (prod[i][j])
                );
                // |q_i| * |d_j|
                tef_mul #(.W(MW)) u_mprod (
                    .aclk (aclk),
                    .en   (en),
                    .a    ($signed({1'b0, mq1[i]})),
                    .b    ($signed({1'b0, md1[j]})),
                    .p    (mprod[i][j])
                );
            end else begin : g_diag
                assign prod[i][j]  = '0;
                assign mprod[i][j] = '0;
            end
        end
    end

    always_comb begin
        logic signed [2*QW:0] diff;
        logic                 dpos;
        for (int f = 0; f < FACE_N; f++) begin
            dpos = !d3_reg[f][QW-1];
            ok_next[f] = (d3_reg[f] != '0) && (q3_reg[f] != '0) &&
                         (q3_reg[f][QW-1] != d3_reg[f][QW-1]);
            gt_next[f] = '0;
            for (int k = 0; k < FACE_N; k++) begin
                if (k != f) begin
                    diff = (2*QW+1)'(prod[k][f]) - (2*QW+1)'(prod[f][k]);
                    if (dpos) begin
                        ok_next[f] = ok_next[f] && !diff[2*QW] && (diff != '0);
                    end else begin
                        ok_next[f] = ok_next[f] && diff[2*QW];
                    end
                    gt_next[f][k] = mprod[f][k] > mprod[k][f];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q2_reg  <= q1_reg;
            d2_reg  <= d1_reg;
            q3_reg  <= q2_reg;
            d3_reg  <= d2_reg;
            q1_reg  <= qin;
            d1_reg  <= din;
            ok4_reg <= ok_next;
            gt4_reg <= gt_next;
            for (int k = 0; k < FACE_N; k++) begin
                mq4_reg[k] <= q3_reg[k][QW-1] ? QW'(-q3_reg[k]) : QW'(q3_reg[k]);
                md4_reg[k] <= d3_reg[k][QW-1] ? QW'(-d3_reg[k]) : QW'(d3_reg[k]);
            end
        end
    end

    always_comb begin
        fnd_next  = 1'b0;
        best_next = '0;
        for (int f = 0; f < FACE_N; f++) begin
            if (ok4_reg[f] && (!fnd_next || gt4_reg[f][best_next])) begin
                fnd_next  = 1'b1;
                best_next = face_t'(f);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fnd5_reg  <= fnd_next;
            best5_reg <= best_next;
            num5_reg  <= mq4_reg[best_next];
            den5_reg  <= md4_reg[best_next];
            side6_reg.found <= fnd5_reg;
            side6_reg.face  <= best5_reg;
            side6_reg.ovf   <= DW'(num5_reg) >= (DW'(den5_reg) << (OUT_W - PARAM_FRAC_BITS));
            rem6_reg  <= DW'(num5_reg) << PARAM_FRAC_BITS;
            den6_reg  <= den5_reg;
        end
    end

    tef_div #(.QW(QW), .DW(DW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_side   (side6_reg),
        .in_rem    (rem6_reg),
        .in_den    (den6_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= dv_side.found;
            face_reg  <= dv_side.found ? dv_side.face : '0;
            param_reg <= !dv_side.found ? '0 : (dv_side.ovf ? '1 : dv_quo);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {6'd0, param_reg, face_reg};
endmodule

// ===== hw/rtl/tef_checker.sv =====
// ----------------------------------------------------------------------------
// tef_checker
// port-level checks of the ray exit face block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tet_ray_exit_face_defines.svh"
module tef_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [191:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata,
    input logic         m_tuser
);
    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata);

    `TEF_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == 40'd0)
    `TEF_ASSERT_IMP(a_hold_valid, m_tvalid && !m_tready, ##1 m_tvalid)
    `TEF_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)
    `TEF_ASSERT_NXT(a_reset_empty, !aresetn, !m_tvalid)
endmodule

bind tet_ray_exit_face tef_checker u_tef_checker (.*);
